// ----- design/tdbs_pkg.sv -----
// Shared types and constants for the two-digit bucket sort core.
package tdbs_pkg;

  localparam int unsigned ValueW   = 7;
  localparam logic [ValueW-1:0] MaxValue = 7'd99;

  typedef logic [ValueW-1:0] value_t;

  typedef struct packed {
    logic   valid;
    value_t value;
  } slot_t;

  typedef struct packed {
    logic   insert;
    logic   shift;
    value_t new_value;
  } ctrl_t;

  typedef enum logic [1:0] {
    ST_LOAD  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

endpackage

// ----- design/tdbs_if.sv -----
// Valid/ready channel interfaces for input and result transactions.
interface tdbs_in_if;
  logic            valid;
  logic            ready;
  tdbs_pkg::value_t value;
  logic            last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface tdbs_out_if;
  logic            valid;
  logic            ready;
  tdbs_pkg::value_t sorted_value;
  logic            final_res;
  logic            overflowed;

  modport source (output valid, output sorted_value, output final_res, output overflowed,
                  input ready);
  modport sink   (input valid, input sorted_value, input final_res, input overflowed,
                  output ready);
endinterface

// ----- design/two_digit_bucket_sort_core.sv -----
// Two-digit sort core: a row of insertion cells kept in ascending order.
// Load: one input transaction per cycle, no result until the last one.
// Drain: after the last transaction, one result per cycle from the next cycle while
// out_ch.ready is high, n results for n stored values; input is held off until the drain ends.
// Reset (synchronous, rst_n low): all cells empty, overflow flag clear, load state.
module two_digit_bucket_sort_core #(
  parameter int unsigned COUNT = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  tdbs_in_if.sink       in_ch,
  tdbs_out_if.source    out_ch
);

  tdbs_pkg::state_t state_r, state_nxt;
  logic             drop_r, drop_nxt;
  tdbs_pkg::ctrl_t  ctrl;
  tdbs_pkg::value_t sat_value;
  tdbs_pkg::slot_t  slots [COUNT];
  logic             keeps [COUNT];
  logic             in_acc;
  logic             out_acc;
  logic             full;

  assign full      = slots[COUNT-1].valid;
  assign in_ch.ready = (state_r == tdbs_pkg::ST_LOAD);
  assign in_acc    = in_ch.valid && in_ch.ready;
  assign sat_value = (in_ch.value > tdbs_pkg::MaxValue) ? tdbs_pkg::MaxValue : in_ch.value;

  assign out_ch.valid        = (state_r == tdbs_pkg::ST_DRAIN) && slots[0].valid;
  assign out_ch.sorted_value = slots[0].value;
  assign out_ch.final_res    = !slots[1].valid;
  assign out_ch.overflowed   = drop_r;
  assign out_acc             = out_ch.valid && out_ch.ready;

  assign ctrl = '{insert: in_acc && !full, shift: out_acc, new_value: sat_value};

  for (genvar i = 0; i < COUNT; i++) begin : g_cell
    tdbs_pkg::slot_t left_s, right_s;
    logic            left_k;
    if (i == 0) begin : g_head
      assign left_s = '{valid: 1'b0, value: '0};
      assign left_k = 1'b1;
    end else begin : g_body
      assign left_s = slots[i-1];
      assign left_k = keeps[i-1];
    end
    if (i == COUNT - 1) begin : g_tail
      assign right_s = '{valid: 1'b0, value: '0};
    end else begin : g_mid
      assign right_s = slots[i+1];
    end
    tdbs_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .left_slot  (left_s),
      .left_keep  (left_k),
      .right_slot (right_s),
      .slot       (slots[i]),
      .keep       (keeps[i])
    );
  end

  always_comb begin
    state_nxt = state_r;
    drop_nxt  = drop_r;
    case (state_r)
      tdbs_pkg::ST_LOAD: begin
        if (in_acc) begin
          if (full) begin
            drop_nxt = 1'b1;
          end
          if (in_ch.last) begin
            state_nxt = tdbs_pkg::ST_DRAIN;
          end
        end
      end
      tdbs_pkg::ST_DRAIN: begin
        if (out_acc && out_ch.final_res) begin
          state_nxt = tdbs_pkg::ST_LOAD;
          drop_nxt  = 1'b0;
        end
      end
      default: begin
        state_nxt = tdbs_pkg::ST_LOAD;
        drop_nxt  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tdbs_pkg::ST_LOAD;
      drop_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      drop_r  <= drop_nxt;
    end
  end

endmodule

// ----- design/tdbs_cell.sv -----
// One sorter cell: holds a slot, inserts in order, shifts toward the head.
module tdbs_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  tdbs_pkg::ctrl_t ctrl,
  input  tdbs_pkg::slot_t left_slot,
  input  logic            left_keep,
  input  tdbs_pkg::slot_t right_slot,
  output tdbs_pkg::slot_t slot,
  output logic            keep
);

  logic             valid_r, valid_nxt;
  tdbs_pkg::value_t value_r, value_nxt;

  assign keep = valid_r && (value_r <= ctrl.new_value);
  assign slot = '{valid: valid_r, value: value_r};

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    if (ctrl.insert) begin
      if (!keep) begin
        if (left_keep) begin
          valid_nxt = 1'b1;
          value_nxt = ctrl.new_value;
        end else begin
          valid_nxt = left_slot.valid;
          value_nxt = left_slot.value;
        end
      end
    end else if (ctrl.shift) begin
      valid_nxt = right_slot.valid;
      value_nxt = right_slot.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    value_r <= value_nxt;
  end

endmodule

// ----- test/tb_two_digit_bucket_sort_core.sv -----
`timescale 1ns / 1ps
// Testbench for the two-digit sort core: directed table and random batches against a bucket model.
module tb_two_digit_bucket_sort_core;

  localparam int Count      = 16;
  localparam int Buckets    = 10;
  localparam int Radix      = 10;
  localparam int NumItems   = 480;
  localparam int IdlePct    = 7;
  localparam int HoldCycles = 300;
  localparam int DrainWait  = 2 * Count + 8;
  localparam int WatchLimit = 4000;
  localparam int MaxPrints  = 50;
  localparam int DirRows    = 13;

  typedef struct packed {
    tdbs_pkg::value_t sorted_value;
    logic             final_res;
    logic             overflowed;
  } sort_res_t;

  typedef struct packed {
    tdbs_pkg::value_t value;
    logic             last;
    int               rep;
    bit               typed;
    tdbs_pkg::value_t exp_value;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic quiet;
  int   stall_req;
  int   err_cnt;
  int   n_items;
  int   idle_cycles = 0;

  tdbs_pkg::value_t batch_vals[$];
  logic             batch_dropped;
  sort_res_t        batch_out[$];
  sort_res_t        sorted_q[$];

  stim_row_t dir_tbl [DirRows] = '{
    '{7'd0,   1'b1, 1,  1'b1, 7'd0},
    '{7'd127, 1'b1, 1,  1'b1, 7'd99},
    '{7'd100, 1'b1, 1,  1'b1, 7'd99},
    '{7'd99,  1'b1, 1,  1'b1, 7'd99},
    '{7'd85,  1'b1, 1,  1'b1, 7'd85},
    '{7'd42,  1'b0, 1,  1'b0, 7'd0},
    '{7'd120, 1'b0, 1,  1'b0, 7'd0},
    '{7'd7,   1'b0, 1,  1'b0, 7'd0},
    '{7'd42,  1'b0, 1,  1'b0, 7'd0},
    '{7'd1,   1'b1, 1,  1'b0, 7'd0},
    '{7'd33,  1'b0, 16, 1'b0, 7'd0},
    '{7'd64,  1'b0, 1,  1'b0, 7'd0},
    '{7'd5,   1'b1, 1,  1'b0, 7'd0}
  };

  tdbs_in_if  in_ch();
  tdbs_out_if out_ch();

  two_digit_bucket_sort_core #(
    .COUNT(Count)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // load one value; on the closing transaction emit the batch by tens, then units digit
  function automatic void bucket_sort_step(tdbs_pkg::value_t raw, logic lst);
    tdbs_pkg::value_t v;
    sort_res_t        r;
    v = (raw > tdbs_pkg::MaxValue) ? tdbs_pkg::MaxValue : raw;
    batch_out.delete();
    if (batch_vals.size() >= Count) begin
      batch_dropped = 1'b1;
    end else begin
      batch_vals.push_back(v);
    end
    if (lst) begin
      for (int t = 0; t < Buckets; t++) begin
        for (int u = 0; u < Radix; u++) begin
          foreach (batch_vals[k]) begin
            if (batch_vals[k] == t * Radix + u) begin
              r.sorted_value = batch_vals[k];
              r.final_res    = 1'b0;
              r.overflowed   = batch_dropped;
              batch_out.push_back(r);
            end
          end
        end
      end
      r = batch_out.pop_back();
      r.final_res = 1'b1;
      batch_out.push_back(r);
      batch_vals.delete();
      batch_dropped = 1'b0;
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    err_cnt++;
    if (err_cnt <= MaxPrints) begin
      $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
    end
  endtask

  task automatic check_result();
    sort_res_t e;
    if (sorted_q.size() == 0) begin
      report_mismatch("unexpected result", out_ch.sorted_value, -1);
      return;
    end
    e = sorted_q.pop_front();
    if (out_ch.sorted_value !== e.sorted_value) begin
      report_mismatch("sorted_value", out_ch.sorted_value, e.sorted_value);
    end
    if (out_ch.final_res !== e.final_res) begin
      report_mismatch("final_res", out_ch.final_res, e.final_res);
    end
    if (out_ch.overflowed !== e.overflowed) begin
      report_mismatch("overflowed", out_ch.overflowed, e.overflowed);
    end
  endtask

  // offer one transaction, hold it until taken, then queue its results
  task automatic send_item(tdbs_pkg::value_t v, logic lst, bit typed,
                           tdbs_pkg::value_t exp_value);
    sort_res_t r;
    while (!quiet && $urandom_range(99) < IdlePct) begin
      in_ch.valid <= 1'b0;
      in_ch.value <= tdbs_pkg::value_t'($urandom);
      in_ch.last  <= 1'($urandom);
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    in_ch.last  <= lst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bucket_sort_step(v, lst);
    if (typed) begin
      r.sorted_value = exp_value;
      r.final_res    = 1'b1;
      r.overflowed   = 1'b0;
      sorted_q.push_back(r);
    end else begin
      foreach (batch_out[k]) sorted_q.push_back(batch_out[k]);
    end
    n_items++;
  endtask

  initial begin
    int               batch_no;
    int               blen;
    int               sel;
    tdbs_pkg::value_t v;
    tdbs_pkg::value_t prev_v;
    in_ch.valid   <= 1'b0;
    in_ch.value   <= '0;
    in_ch.last    <= 1'b0;
    rst_n         <= 1'b0;
    quiet         <= 1'b0;
    stall_req     <= 0;
    err_cnt       = 0;
    n_items       = 0;
    batch_dropped = 1'b0;
    prev_v        = '0;
    batch_no      = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DirRows; i++) begin
      repeat (dir_tbl[i].rep) begin
        send_item(dir_tbl[i].value, dir_tbl[i].last, dir_tbl[i].typed, dir_tbl[i].exp_value);
      end
    end

    while (n_items < NumItems) begin
      if (batch_no == 0) stall_req <= stall_req + 1;
      if (batch_no == 6) quiet <= 1'b1;
      if (batch_no == 14) quiet <= 1'b0;
      if (batch_no == 22) begin
        in_ch.valid <= 1'b0;
        while (sorted_q.size() != 0) @(posedge clk);
      end
      sel = $urandom_range(99);
      if (batch_no == 0) begin
        blen = Count + 8;
      end else if (sel < 65) begin
        blen = $urandom_range(Count, 1);
      end else if (sel < 82) begin
        blen = $urandom_range(3, 1);
      end else begin
        blen = $urandom_range(Count + 6, Count);
      end
      for (int i = 0; i < blen; i++) begin
        sel = $urandom_range(99);
        if (sel < 80) begin
          v = tdbs_pkg::value_t'($urandom_range(99));
        end else if (sel < 90) begin
          v = prev_v;
        end else begin
          v = tdbs_pkg::value_t'($urandom_range(127));
        end
        send_item(v, i == blen - 1, 1'b0, '0);
        prev_v = v;
      end
      batch_no++;
    end

    in_ch.valid <= 1'b0;
    while (sorted_q.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb_two_digit_bucket_sort_core: done, clean");
    end else begin
      $display("tb_two_digit_bucket_sort_core: done, errors");
    end
    $finish;
  end

  initial begin
    int hold_left;
    int stall_seen;
    hold_left  = 0;
    stall_seen = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) check_result();
      if (stall_req != stall_seen) begin
        stall_seen = stall_req;
        hold_left  = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= quiet || ($urandom_range(99) >= IdlePct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchLimit) begin
      $display("tb_two_digit_bucket_sort_core: done, errors");
      $finish;
    end
  end

endmodule

// ----- filelist.f -----
design/tdbs_pkg.sv
design/tdbs_if.sv
design/tdbs_cell.sv
design/two_digit_bucket_sort_core.sv
test/tb_two_digit_bucket_sort_core.sv
